>>> design/sgma_pkg.sv
// shared types, constants and helpers for the sobel gradient block
package sgma_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int CORDIC_STEPS = 16;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int CNT_W        = $clog2(MAX_WIDTH + 1);

    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_KERNEL_X = 2'd2;
    localparam logic [1:0] CFG_KERNEL_Y = 2'd3;

    localparam logic [11:0] WIDTH_RESET    = 12'd640;
    localparam logic [15:0] HEIGHT_RESET   = 16'd480;
    localparam logic [35:0] KERNEL_X_RESET = 36'd4548780303;
    localparam logic [35:0] KERNEL_Y_RESET = 36'd4848619503;

    localparam logic signed [22:0] ANGLE_PI20 = 23'sd3294199;
    localparam logic signed [14:0] ANGLE_PI12 = 15'sd12868;

    // one 3x3 neighbourhood, row-major, row*3+column
    typedef struct packed {
        logic [8:0][7:0] pix;
        logic            last;
    } t_window;

    function automatic logic signed [22:0] arc_entry(input logic [4:0] i);
        logic signed [22:0] v;
        case (i)
            5'd0:    v = 23'sd823550;
            5'd1:    v = 23'sd486170;
            5'd2:    v = 23'sd256879;
            5'd3:    v = 23'sd130396;
            5'd4:    v = 23'sd65451;
            5'd5:    v = 23'sd32757;
            5'd6:    v = 23'sd16383;
            5'd7:    v = 23'sd8192;
            5'd8:    v = 23'sd4096;
            5'd9:    v = 23'sd2048;
            5'd10:   v = 23'sd1024;
            5'd11:   v = 23'sd512;
            5'd12:   v = 23'sd256;
            5'd13:   v = 23'sd128;
            5'd14:   v = 23'sd64;
            5'd15:   v = 23'sd32;
            5'd16:   v = 23'sd16;
            5'd17:   v = 23'sd8;
            5'd18:   v = 23'sd4;
            5'd19:   v = 23'sd2;
            5'd20:   v = 23'sd1;
            default: v = 23'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/sgma_stream_if.sv
// valid/ready channel carrying a payload
interface sgma_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/sgma_front.sv
// line stores, window and border handling; emits up to four windows per pixel
module sgma_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [11:0]                 i_width,
    input  logic [15:0]                 i_height,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output sgma_pkg::t_window           o_win
);

    // phase 0: read line stores; phase 1: emit windows one by one
    logic [7:0] r_older [sgma_pkg::MAX_WIDTH];
    logic [7:0] r_newer [sgma_pkg::MAX_WIDTH];
    logic [7:0] r_rd_old, r_rd_new;

    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_pix;
    logic [sgma_pkg::COL_W-1:0] r_x;
    logic [15:0] r_y;
    logic [sgma_pkg::CNT_W-1:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [7:0] r_p2 [3];
    logic [7:0] r_p1 [3];
    logic       r_rdy;

    logic [sgma_pkg::CNT_W-1:0] w_eff;
    logic [15:0] h_eff;
    logic [sgma_pkg::CNT_W-1:0] x_now;
    logic [15:0] y_now;
    logic [7:0] cur [3];
    logic       lastrow, lastcol, colok;
    logic [2:0] n_res;
    logic       is_right;
    logic       second;
    logic [7:0] lc [3];
    logic [7:0] mc [3];
    logic [7:0] rc [3];
    logic [1:0] rsel [3];

    always_comb begin
        w_eff = (i_width < 12'd2) ? sgma_pkg::CNT_W'(2) : sgma_pkg::CNT_W'(i_width);
        if (w_eff > sgma_pkg::CNT_W'(sgma_pkg::MAX_WIDTH))
            w_eff = sgma_pkg::CNT_W'(sgma_pkg::MAX_WIDTH);
        h_eff = (i_height < 16'd2) ? 16'd2 : i_height;
        x_now = (r_col > w_eff - 1'b1) ? w_eff - 1'b1 : r_col;
        y_now = (r_row > h_eff - 1'b1) ? h_eff - 1'b1 : r_row;
    end

    assign o_ready = r_rdy;

    // pixel-level quantities of the pending pixel
    always_comb begin
        cur[0]  = r_rd_old;
        cur[1]  = r_rd_new;
        cur[2]  = r_pix;
        lastrow = (r_y == h_eff - 1'b1);
        lastcol = ({1'b0, r_x} == w_eff - 1'b1);
        colok   = (r_x != '0);
        n_res   = '0;
        if (r_y != 16'd0) begin
            n_res = (colok ? 3'd1 : 3'd0) + (lastcol ? 3'd1 : 3'd0);
            if (lastrow)
                n_res = {n_res[1:0], 1'b0};
        end
        second   = lastrow & r_idx[0];
        is_right = lastrow ? (colok ? r_idx[1] : 1'b1) : (colok ? r_idx[0] : 1'b1);
        for (int k = 0; k < 3; k++) begin
            if (is_right) begin
                lc[k] = r_p1[k];
                mc[k] = cur[k];
                rc[k] = r_p1[k];
            end else begin
                lc[k] = (r_x == sgma_pkg::COL_W'(1)) ? cur[k] : r_p2[k];
                mc[k] = r_p1[k];
                rc[k] = cur[k];
            end
        end
        if (second) begin
            rsel[0] = 2'd1; rsel[1] = 2'd2; rsel[2] = 2'd1;
        end else begin
            rsel[0] = (r_y == 16'd1) ? 2'd2 : 2'd0;
            rsel[1] = 2'd1;
            rsel[2] = 2'd2;
        end
        for (int r = 0; r < 3; r++) begin
            o_win.pix[r*3+0] = lc[rsel[r]];
            o_win.pix[r*3+1] = mc[rsel[r]];
            o_win.pix[r*3+2] = rc[rsel[r]];
        end
        o_win.last = is_right & second;
    end

    assign o_valid = r_busy && ({1'b0, r_idx} < n_res);

    logic phase;
    logic done;
    always_comb begin
        done   = r_busy && (({1'b0, r_idx} >= n_res) ||
                 (i_ready && ({1'b0, r_idx} + 3'd1 >= n_res)));
        n_busy = r_busy;
        n_idx  = r_idx;
        n_col  = r_col;
        n_row  = r_row;
        if (r_busy) begin
            if (done) begin
                n_busy = 1'b0;
                n_idx  = '0;
                if (lastcol) begin
                    n_col = '0;
                    n_row = lastrow ? 16'd0 : r_y + 16'd1;
                end else begin
                    n_col = sgma_pkg::CNT_W'(r_x) + 1'b1;
                end
            end else if (i_ready) begin
                n_idx = r_idx + 2'd1;
            end
        end
    end
    assign phase = r_rdy & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rdy  <= 1'b1;
            r_idx  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_p2[k] <= '0;
                r_p1[k] <= '0;
            end
        end else begin
            r_idx <= n_idx;
            r_col <= n_col;
            r_row <= n_row;
            if (phase) begin
                r_rdy  <= 1'b0;
                r_busy <= 1'b1;
                r_pix  <= i_pixel;
                r_x    <= x_now[sgma_pkg::COL_W-1:0];
                r_y    <= y_now;
            end else begin
                r_busy <= n_busy;
                if (done) begin
                    r_rdy <= 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_p2[k] <= r_p1[k];
                        r_p1[k] <= cur[k];
                    end
                end
            end
        end
    end

    // line stores: read on accept, write back when the pixel retires
    always_ff @(posedge i_clk) begin
        if (phase) begin
            r_rd_old <= r_older[x_now[sgma_pkg::COL_W-1:0]];
            r_rd_new <= r_newer[x_now[sgma_pkg::COL_W-1:0]];
        end
        if (done) begin
            r_older[r_x] <= r_rd_new;
            r_newer[r_x] <= r_pix;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("accept while busy");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_idx} < n_res)) else $error("window index past count");
    a_ready_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_ready) else $error("ready not restored");
`endif

endmodule

>>> design/sgma_back.sv
// convolution, integer square root and cordic angle for one window
module sgma_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [35:0]       i_kx,
    input  logic [35:0]       i_ky,
    input  logic              i_valid,
    output logic              o_ready,
    input  sgma_pkg::t_window i_win,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [14:0]       o_magnitude,
    output logic [14:0]       o_direction,
    output logic              o_frame_end
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_st;
    sgma_pkg::t_window r_win;
    logic [3:0]  r_k;
    logic signed [15:0] r_gx, r_gy;
    logic [31:0] r_v, r_res, r_bit;
    logic signed [35:0] r_cx, r_cy;
    logic signed [22:0] r_z, r_off;
    logic [4:0]  r_i;
    logic        r_zero;
    logic [14:0] r_mag, r_dir;
    logic        r_last;

    logic signed [4:0]  tx, ty;
    logic signed [15:0] px;
    logic signed [31:0] sq_x, sq_y;
    logic [31:0]        sumsq;
    logic signed [35:0] dx, dy;
    logic [31:0]        trial;
    logic signed [22:0] zf;
    logic signed [22:0] qa;
    logic signed [14:0] q;

    always_comb begin
        tx    = 5'(signed'(i_kx[r_k*4 +: 4]));
        ty    = 5'(signed'(i_ky[r_k*4 +: 4]));
        px    = 16'(signed'({1'b0, r_win.pix[r_k]}));
        sq_x  = r_gx * r_gx;
        sq_y  = r_gy * r_gy;
        sumsq = 32'(sq_x) + 32'(sq_y);
        dx    = r_cy >>> r_i;
        dy    = r_cx >>> r_i;
        trial = r_res + r_bit;
        zf    = r_z + r_off;
        if (zf >= 0)
            qa = (zf + 23'sd128) >>> 8;
        else
            qa = -((-zf + 23'sd128) >>> 8);
        if (qa > 23'(sgma_pkg::ANGLE_PI12))
            q = sgma_pkg::ANGLE_PI12;
        else if (qa < -23'(sgma_pkg::ANGLE_PI12))
            q = -sgma_pkg::ANGLE_PI12;
        else
            q = qa[14:0];
    end

    assign o_ready     = (r_st == ST_IDLE);
    assign o_valid     = (r_st == ST_OUT);
    assign o_magnitude = r_mag;
    assign o_direction = r_dir;
    assign o_frame_end = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_win <= i_win;
                        r_k   <= '0;
                        r_gx  <= '0;
                        r_gy  <= '0;
                        r_st  <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_gx <= r_gx + 16'(tx * px);
                    r_gy <= r_gy + 16'(ty * px);
                    if (r_k == 4'd8)
                        r_st <= ST_SQ;
                    else
                        r_k <= r_k + 4'd1;
                end
                ST_SQ: begin
                    r_v    <= sumsq;
                    r_res  <= '0;
                    r_bit  <= 32'h4000_0000;
                    r_last <= r_win.last;
                    r_zero <= (r_gx == 0);
                    r_z    <= '0;
                    r_i    <= '0;
                    if (r_gy < 0) begin
                        r_cx  <= -(36'(r_gy) <<< 10);
                        r_cy  <= -(36'(r_gx) <<< 10);
                        r_off <= (r_gx > 0) ? sgma_pkg::ANGLE_PI20 : -sgma_pkg::ANGLE_PI20;
                    end else begin
                        r_cx  <= 36'(r_gy) <<< 10;
                        r_cy  <= 36'(r_gx) <<< 10;
                        r_off <= '0;
                    end
                    r_st <= ST_RUN;
                end
                ST_RUN: begin
                    // one root digit and one cordic rotation per cycle
                    if (r_bit != 0) begin
                        if (r_v >= trial) begin
                            r_v   <= r_v - trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                    if (32'(r_i) < 32'(sgma_pkg::CORDIC_STEPS)) begin
                        if (r_cy >= 0) begin
                            r_cx <= r_cx + dx;
                            r_cy <= r_cy - dy;
                            r_z  <= r_z + sgma_pkg::arc_entry(r_i);
                        end else begin
                            r_cx <= r_cx - dx;
                            r_cy <= r_cy + dy;
                            r_z  <= r_z - sgma_pkg::arc_entry(r_i);
                        end
                        r_i <= r_i + 5'd1;
                    end
                    if (r_bit == 0 && 32'(r_i) >= 32'(sgma_pkg::CORDIC_STEPS))
                        r_st <= ST_FIN;
                end
                ST_FIN: begin
                    r_mag <= 15'((r_v > r_res) ? r_res + 32'd1 : r_res);
                    if (r_zero)
                        r_dir <= r_off != 0 ? sgma_pkg::ANGLE_PI12 : 15'd0;
                    else
                        r_dir <= q;
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_ready)
                        r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_magnitude <= 15'd25966)) else $error("magnitude out of range");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_st == ST_SUM)) else $error("window not taken");
`endif

endmodule

>>> design/sgma_fifo.sv
// two-entry queue of windows between front and back
module sgma_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sgma_pkg::t_window i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output sgma_pkg::t_window o_data
);
    sgma_pkg::t_window r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid & o_ready;
    assign rd = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("pointer skew");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("count slip");
`endif

endmodule

>>> design/sobel_gradient_magnitude_angle_top.sv
// 3x3 gradient block: magnitude and direction of each pixel's neighbourhood
// Pixels stream in raster order; results come one row and one column late,
// mirrored at the borders. Each pixel passes the front as a line-store read,
// then window issue, which issues any extra border results one after another.
// Each result passes the back as window take, tap accumulation, squaring, the
// shared root/cordic iteration loop, rounding and hand-out; the back takes
// no new window until it has handed out the last result. A two-entry queue
// lets the front run ahead.
module sobel_gradient_magnitude_angle_top (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [35:0] i_cfg_data,
    sgma_stream_if.sink   pix_in,
    sgma_stream_if.source res_out
);
    logic [11:0] r_width;
    logic [15:0] r_height;
    logic [35:0] r_kx, r_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sgma_pkg::WIDTH_RESET;
            r_height <= sgma_pkg::HEIGHT_RESET;
            r_kx     <= sgma_pkg::KERNEL_X_RESET;
            r_ky     <= sgma_pkg::KERNEL_Y_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgma_pkg::CFG_WIDTH:    r_width  <= i_cfg_data[11:0];
                sgma_pkg::CFG_HEIGHT:   r_height <= i_cfg_data[15:0];
                sgma_pkg::CFG_KERNEL_X: r_kx     <= i_cfg_data;
                sgma_pkg::CFG_KERNEL_Y: r_ky     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    sgma_pkg::t_window f_win, q_win;
    logic [14:0] mag, dir;
    logic fe;

    sgma_front u_front (
        .i_clk, .i_rst_n,
        .i_width(r_width), .i_height(r_height),
        .i_valid(pix_in.valid), .o_ready(pix_in.ready), .i_pixel(pix_in.data),
        .o_valid(f_valid), .i_ready(f_ready), .o_win(f_win)
    );

    sgma_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_win),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_win)
    );

    sgma_back u_back (
        .i_clk, .i_rst_n,
        .i_kx(r_kx), .i_ky(r_ky),
        .i_valid(q_valid), .o_ready(q_ready), .i_win(q_win),
        .o_valid(res_out.valid), .i_ready(res_out.ready),
        .o_magnitude(mag), .o_direction(dir), .o_frame_end(fe)
    );

    assign res_out.data = {mag, dir, fe};

endmodule
